// ===== src/dlmc_pkg.sv =====
package dlmc_pkg;

    localparam int unsigned CntW      = 16;
    localparam int unsigned DutyW     = 8;
    localparam int unsigned ModeW     = 2;
    localparam int unsigned CfgIdxW   = 8;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [CntW-1:0]  CntSat      = 16'hFFFF;
    localparam logic [DutyW-1:0] FullDuty    = 8'd255;
    localparam logic [CntW-1:0]  DebounceRst = 16'd30;
    localparam logic [CntW-1:0]  BlinkRst    = 16'd500;
    localparam logic [CntW-1:0]  FadeIntRst  = 16'd10;
    localparam logic [DutyW-1:0] FadeStepRst = 8'd5;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SETTLE_TICKS = 8'd0,
        CFG_BLINK_PERIOD = 8'd1,
        CFG_FADE_PERIOD  = 8'd2,
        CFG_FADE_STEP    = 8'd3
    } t_cfg_index;

    typedef enum logic [ModeW-1:0] {
        MODE_OFF   = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_ON    = 2'd2,
        MODE_FADE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CntW-1:0]  settle_ticks;
        logic [CntW-1:0]  blink_period;
        logic [CntW-1:0]  fade_period;
        logic [DutyW-1:0] fade_step;
    } t_cfg;

    typedef struct packed {
        logic [DutyW-1:0] yellow;
        logic [DutyW-1:0] green;
        logic [DutyW-1:0] red;
        t_mode            mode;
    } t_result;

    typedef struct packed {
        logic cycle_press;
        logic clear_press;
    } t_press;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntSat) ? CntSat : v + 1'b1;
    endfunction

endpackage

// ===== src/debounced_led_mode_controller.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_cycle_button_level, i_clear_button_level
// out      output     o_out_valid / i_out_stall  o_yellow_duty, o_green_duty, o_red_duty,
//                                                o_led_mode
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per cycle unless o_in_stall; result is registered, in the skid if one waits.
// Debounce, mode and duty update are done in the accepting cycle, result register after.
// Synchronous active-low reset restores config defaults, clears state but output payloads.
// A two-entry output buffer absorbs one stalled result; o_in_stall rises only when full.
module debounced_led_mode_controller
    import dlmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cycle_button_level,
    input  logic                i_clear_button_level,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DutyW-1:0]    o_yellow_duty,
    output logic [DutyW-1:0]    o_green_duty,
    output logic [DutyW-1:0]    o_red_duty,
    output logic [ModeW-1:0]    o_led_mode,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_press  press;
    t_result core_result;
    t_result out_result;
    logic    full;
    logic    step;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign step        = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks <= DebounceRst;
            r_cfg.blink_period <= BlinkRst;
            r_cfg.fade_period  <= FadeIntRst;
            r_cfg.fade_step    <= FadeStepRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SETTLE_TICKS: r_cfg.settle_ticks <= i_cfg_data;
                CFG_BLINK_PERIOD: r_cfg.blink_period <= i_cfg_data;
                CFG_FADE_PERIOD:  r_cfg.fade_period  <= i_cfg_data;
                CFG_FADE_STEP:    r_cfg.fade_step    <= i_cfg_data[DutyW-1:0];
                default:          r_cfg.fade_step    <= r_cfg.fade_step;
            endcase
        end
    end

    dlmc_debounce u_cycle_db (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_raw          (i_cycle_button_level),
        .i_settle_ticks (r_cfg.settle_ticks),
        .o_press        (press.cycle_press)
    );

    dlmc_debounce u_clear_db (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_raw          (i_clear_button_level),
        .i_settle_ticks (r_cfg.settle_ticks),
        .o_press        (press.clear_press)
    );

    dlmc_mode_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_press  (press),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    dlmc_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (step),
        .i_result (core_result),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_yellow_duty = out_result.yellow;
    assign o_green_duty  = out_result.green;
    assign o_red_duty    = out_result.red;
    assign o_led_mode    = out_result.mode;

endmodule

// ===== src/dlmc_debounce.sv =====
module dlmc_debounce
    import dlmc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_raw,
    input  logic [CntW-1:0] i_settle_ticks,
    output logic            o_press
);

    logic            r_prev;
    logic            r_stable;
    logic [CntW-1:0] r_quiet;
    logic [CntW-1:0] n_quiet;
    logic            n_stable;
    logic            take;

    always_comb begin
        n_quiet  = (i_raw != r_prev) ? '0 : sat_inc(r_quiet);
        take     = (n_quiet >= i_settle_ticks);
        n_stable = take ? i_raw : r_stable;
        o_press  = take && r_stable && !i_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_stable <= 1'b1;
            r_quiet  <= '0;
        end else if (i_step) begin
            r_prev   <= i_raw;
            r_stable <= n_stable;
            r_quiet  <= n_quiet;
        end
    end

endmodule

// ===== src/dlmc_mode_core.sv =====
module dlmc_mode_core
    import dlmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_press  i_press,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_mode            r_mode,        n_mode;
    logic             r_blink_phase, n_blink_phase;
    logic [CntW-1:0]  r_blink_el,    n_blink_el;
    logic [DutyW-1:0] r_fade_level,  n_fade_level;
    logic             r_fade_rising, n_fade_rising;
    logic [CntW-1:0]  r_fade_el,     n_fade_el;
    logic [DutyW-1:0] r_yel, r_grn, r_red;
    logic [DutyW-1:0] n_yel, n_grn, n_red;
    logic             restart;
    logic [DutyW+1:0] ramp;
    logic             ramp_hi;
    logic             ramp_lo;

    always_comb begin
        restart       = i_press.cycle_press || i_press.clear_press;
        n_mode        = r_mode;
        n_yel         = r_yel;
        n_grn         = r_grn;
        n_red         = r_red;
        n_blink_phase = r_blink_phase;
        n_blink_el    = sat_inc(r_blink_el);
        n_fade_level  = r_fade_level;
        n_fade_rising = r_fade_rising;
        n_fade_el     = sat_inc(r_fade_el);
        if (i_press.cycle_press) begin
            n_mode = t_mode'(r_mode + 1'b1);
        end
        if (i_press.clear_press) begin
            n_mode = MODE_OFF;
        end
        if (restart) begin
            n_blink_phase = 1'b0;
            n_blink_el    = '0;
            n_fade_level  = '0;
            n_fade_rising = 1'b1;
            n_fade_el     = '0;
        end

        if (n_fade_rising) begin
            ramp = {2'b00, n_fade_level} + {2'b00, i_cfg.fade_step};
        end else begin
            ramp = {2'b00, n_fade_level} - {2'b00, i_cfg.fade_step};
        end
        ramp_hi = !ramp[DutyW+1] && (ramp[DutyW:0] >= {1'b0, FullDuty});
        ramp_lo = ramp[DutyW+1] || (ramp == '0);

        case (n_mode)
            MODE_OFF: begin
                n_yel = '0;
                n_grn = '0;
                n_red = '0;
            end
            MODE_BLINK: begin
                if (n_blink_el >= i_cfg.blink_period) begin
                    n_blink_phase = !n_blink_phase;
                    n_blink_el    = '0;
                end
                n_yel = n_blink_phase ? FullDuty : '0;
                n_grn = n_blink_phase ? '0 : FullDuty;
                n_red = n_blink_phase ? FullDuty : '0;
            end
            MODE_ON: begin
                n_yel = FullDuty;
                n_grn = FullDuty;
                n_red = FullDuty;
            end
            MODE_FADE: begin
                if (n_fade_el >= i_cfg.fade_period) begin
                    if (ramp_hi) begin
                        n_fade_level  = FullDuty;
                        n_fade_rising = 1'b0;
                    end else if (ramp_lo) begin
                        n_fade_level  = '0;
                        n_fade_rising = 1'b1;
                    end else begin
                        n_fade_level = ramp[DutyW-1:0];
                    end
                    n_yel     = n_fade_level;
                    n_grn     = n_fade_level;
                    n_red     = n_fade_level;
                    n_fade_el = '0;
                end
            end
            default: begin
                n_yel = r_yel;
            end
        endcase

        o_result = '{yellow: n_yel, green: n_grn, red: n_red, mode: n_mode};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFF;
            r_blink_phase <= 1'b0;
            r_blink_el    <= '0;
            r_fade_level  <= '0;
            r_fade_rising <= 1'b1;
            r_fade_el     <= '0;
            r_yel         <= '0;
            r_grn         <= '0;
            r_red         <= '0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_blink_phase <= n_blink_phase;
            r_blink_el    <= n_blink_el;
            r_fade_level  <= n_fade_level;
            r_fade_rising <= n_fade_rising;
            r_fade_el     <= n_fade_el;
            r_yel         <= n_yel;
            r_grn         <= n_grn;
            r_red         <= n_red;
        end
    end

endmodule

// ===== src/dlmc_out_skid.sv =====
module dlmc_out_skid
    import dlmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || pop) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (r_out_valid && !pop && i_push) begin
            r_skid <= i_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> r_out_valid)
        else $error("pushed request not shown");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> r_skid_valid)
        else $error("skid entry dropped");

endmodule

// ===== tb/debounced_led_mode_controller_test.sv =====
`timescale 1ns / 1ps

module debounced_led_mode_controller_test;
    import dlmc_pkg::*;

    localparam int unsigned IdleLimit = 5000;
    localparam int unsigned RandomPerPhase = 90;
    localparam int unsigned LongHoldTicks = 40;
    localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd4;
    localparam logic [CfgIdxW-1:0] CfgIdxTop = 8'hFF;

    class duty_scoreboard;
        logic [CntW-1:0]  settle_ticks;
        logic [CntW-1:0]  blink_period;
        logic [CntW-1:0]  fade_period;
        logic [DutyW-1:0] fade_step;
        logic             prev_raw [2];
        logic             stable [2];
        logic [CntW-1:0]  quiet [2];
        t_mode            mode_reg;
        logic             blink_phase;
        logic [CntW-1:0]  blink_elapsed;
        logic [CntW-1:0]  fade_elapsed;
        logic [DutyW-1:0] fade_level;
        logic             fade_rising;
        logic [DutyW-1:0] held [3];
        t_result          expected_duties [$];
        int unsigned      n_errors;
        int unsigned      n_checked;
        int unsigned      n_cycle_presses;
        int unsigned      n_clear_presses;
        int unsigned      n_fade_steps;

        function new();
            settle_ticks = DebounceRst;
            blink_period = BlinkRst;
            fade_period = FadeIntRst;
            fade_step = FadeStepRst;
            for (int b = 0; b < 2; b++) begin
                prev_raw[b] = 1'b1;
                stable[b] = 1'b1;
                quiet[b] = '0;
            end
            mode_reg = MODE_OFF;
            restart();
            set_duties('0, '0, '0);
            n_errors = 0;
            n_checked = 0;
            n_cycle_presses = 0;
            n_clear_presses = 0;
            n_fade_steps = 0;
        endfunction

        function logic [CntW-1:0] bump(input logic [CntW-1:0] v);
            return (&v) ? v : v + 16'd1;
        endfunction

        function void restart();
            fade_level = '0;
            fade_rising = 1'b1;
            blink_phase = 1'b0;
            blink_elapsed = '0;
            fade_elapsed = '0;
        endfunction

        function void set_duties(input logic [DutyW-1:0] y, input logic [DutyW-1:0] g,
                                 input logic [DutyW-1:0] r);
            held[0] = y;
            held[1] = g;
            held[2] = r;
        endfunction

        function void write_config(input logic [CfgIdxW-1:0] index,
                                   input logic [CfgDataW-1:0] data);
            case (index)
                CFG_SETTLE_TICKS: settle_ticks = data;
                CFG_BLINK_PERIOD: blink_period = data;
                CFG_FADE_PERIOD:  fade_period = data;
                CFG_FADE_STEP:    fade_step = data[DutyW-1:0];
                default: ;
            endcase
        endfunction

        function bit button_press(input int b, input logic raw);
            bit pressed;
            pressed = 1'b0;
            quiet[b] = (raw != prev_raw[b]) ? '0 : bump(quiet[b]);
            if (quiet[b] >= settle_ticks) begin
                pressed = stable[b] && !raw;
                stable[b] = raw;
            end
            prev_raw[b] = raw;
            return pressed;
        endfunction

        function void note_tick(input logic cyc, input logic clr);
            int               level;
            int               step_size;
            logic [ModeW-1:0] next_mode;
            t_result          want;
            blink_elapsed = bump(blink_elapsed);
            fade_elapsed = bump(fade_elapsed);
            if (button_press(0, cyc)) begin
                next_mode = mode_reg + 2'd1;
                mode_reg = t_mode'(next_mode);
                restart();
                n_cycle_presses++;
            end
            if (button_press(1, clr)) begin
                mode_reg = MODE_OFF;
                set_duties('0, '0, '0);
                restart();
                n_clear_presses++;
            end
            case (mode_reg)
                MODE_OFF: set_duties('0, '0, '0);
                MODE_BLINK: begin
                    if (blink_elapsed >= blink_period) begin
                        blink_phase = !blink_phase;
                        blink_elapsed = '0;
                    end
                    if (blink_phase) set_duties(FullDuty, '0, FullDuty);
                    else set_duties('0, FullDuty, '0);
                end
                MODE_ON: set_duties(FullDuty, FullDuty, FullDuty);
                MODE_FADE: begin
                    if (fade_elapsed >= fade_period) begin
                        level = int'(fade_level);
                        step_size = int'(fade_step);
                        level = fade_rising ? level + step_size : level - step_size;
                        if (level >= int'(FullDuty)) begin
                            level = int'(FullDuty);
                            fade_rising = 1'b0;
                        end
                        if (level <= 0) begin
                            level = 0;
                            fade_rising = 1'b1;
                        end
                        fade_level = level[DutyW-1:0];
                        set_duties(fade_level, fade_level, fade_level);
                        fade_elapsed = '0;
                        n_fade_steps++;
                    end
                end
                default: ;
            endcase
            want.yellow = held[0];
            want.green = held[1];
            want.red = held[2];
            want.mode = mode_reg;
            expected_duties.push_back(want);
        endfunction

        function void compare_field(input string name, input logic [DutyW-1:0] want,
                                    input logic [DutyW-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (expected_duties.size() == 0) begin
                $error("result with no pending tick: yellow %0d green %0d red %0d mode %0d",
                       got.yellow, got.green, got.red, got.mode);
                n_errors++;
                return;
            end
            want = expected_duties.pop_front();
            n_checked++;
            compare_field("yellow_duty", want.yellow, got.yellow);
            compare_field("green_duty", want.green, got.green);
            compare_field("red_duty", want.red, got.red);
            compare_field("led_mode", DutyW'(want.mode), DutyW'(got.mode));
        endfunction

        function int unsigned pending();
            return expected_duties.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_cycle_button_level;
    logic                i_clear_button_level;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DutyW-1:0]    o_yellow_duty;
    logic [DutyW-1:0]    o_green_duty;
    logic [DutyW-1:0]    o_red_duty;
    logic [ModeW-1:0]    o_led_mode;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    duty_scoreboard sb = new();
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    int unsigned    idle_cycles = 0;
    int unsigned    n_settings = 0;
    logic [CntW-1:0] cfg_debounce = DebounceRst;

    debounced_led_mode_controller u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cycle_button_level (i_cycle_button_level),
        .i_clear_button_level (i_clear_button_level),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_yellow_duty        (o_yellow_duty),
        .o_green_duty         (o_green_duty),
        .o_red_duty           (o_red_duty),
        .o_led_mode           (o_led_mode),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_tick(i_cycle_button_level, i_clear_button_level);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(t_result'({o_yellow_duty, o_green_duty, o_red_duty, o_led_mode}));
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("debounced_led_mode_controller test failed");
            $finish;
        end
    end

    function void set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endfunction

    task automatic send_tick(input logic cyc, input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_cycle_button_level <= 1'($urandom_range(0, 1));
            i_clear_button_level <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cycle_button_level <= cyc;
        i_clear_button_level <= clr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic hold_levels(input logic cyc, input logic clr, input int unsigned n);
        repeat (n) send_tick(cyc, clr);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_config(index, data);
    endtask

    task automatic apply_settings(input logic [CntW-1:0] deb, input logic [CntW-1:0] blink,
                                  input logic [CntW-1:0] fint, input logic [DutyW-1:0] step);
        logic [CfgDataW-DutyW-1:0] filler;
        logic [CfgIdxW-1:0]        spare;
        filler = (CfgDataW-DutyW)'($urandom);
        spare = CfgIdxW'($urandom_range(CfgIdxSpare, CfgIdxTop));
        wait_drain();
        write_reg(CFG_SETTLE_TICKS, deb);
        write_reg(CFG_BLINK_PERIOD, blink);
        write_reg(CFG_FADE_PERIOD, fint);
        write_reg(CFG_FADE_STEP, {filler, step});
        // a write to no register must leave the settings alone
        write_reg(spare, CfgDataW'($urandom));
        i_cfg_valid <= 1'b0;
        cfg_debounce = deb;
        n_settings++;
    endtask

    task automatic random_levels(input int unsigned n);
        int unsigned left;
        int unsigned run;
        logic        cyc;
        logic        clr;
        left = n;
        while (left > 0) begin
            cyc = 1'($urandom_range(0, 1));
            clr = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) == 0) begin
                run = $urandom_range(1, (cfg_debounce > 0) ? cfg_debounce : 1);
            end else begin
                run = cfg_debounce + 1 + $urandom_range(0, 3);
            end
            if (run > left) run = left;
            hold_levels(cyc, clr, run);
            left -= run;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cycle_button_level <= 1'b1;
        i_clear_button_level <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        set_idling(29, 63);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        hold_levels(1'b1, 1'b1, 2);

        apply_settings(16'd0, 16'd2, 16'd0, 8'd255);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 3);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 2);
        hold_levels(1'b0, 1'b0, 1);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b0, 1);
        hold_levels(1'b1, 1'b1, 1);

        apply_settings(16'd0, 16'd2, 16'd1, 8'd0);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 2);

        // a one-tick glitch must not count as a press
        apply_settings(16'd2, 16'd1, 16'd3, 8'd100);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 3);

        apply_settings(16'd1, 16'd3, 16'd2, 8'd37);
        random_levels(RandomPerPhase);
        apply_settings(16'd4, 16'd1, 16'd1, 8'd1);
        random_levels(RandomPerPhase);

        set_idling(63, 29);
        apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 8'd255);
        random_levels(RandomPerPhase);
        apply_settings(16'd3, 16'd0, 16'd0, 8'd128);
        random_levels(RandomPerPhase);

        set_idling(0, 0);
        apply_settings(CntW'($urandom_range(0, 6)), CntW'($urandom_range(0, 8)),
                       CntW'($urandom_range(0, 4)), DutyW'($urandom_range(0, 255)));
        random_levels(RandomPerPhase);
        apply_settings(DebounceRst, BlinkRst, FadeIntRst, FadeStepRst);
        random_levels(RandomPerPhase);

        // settle both buttons released, then press through a long debounce
        hold_levels(1'b1, 1'b1, cfg_debounce + 2);
        apply_settings(16'd36, 16'd7, 16'd3, 8'd9);
        hold_levels(1'b0, 1'b1, LongHoldTicks);
        hold_levels(1'b1, 1'b1, 2);

        wait_drain();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d ticks over %0d register settings, %0d of them after one long hold",
                 sb.n_checked, n_settings, LongHoldTicks);
        $display("Saw %0d cycle presses, %0d clear presses and %0d fade steps",
                 sb.n_cycle_presses, sb.n_clear_presses, sb.n_fade_steps);
        if (sb.n_errors == 0) begin
            $display("debounced_led_mode_controller test passed");
        end else begin
            $display("debounced_led_mode_controller test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/dlmc_pkg.sv
src/dlmc_debounce.sv
src/dlmc_mode_core.sv
src/dlmc_out_skid.sv
src/debounced_led_mode_controller.sv
tb/debounced_led_mode_controller_test.sv
